// ===== sv/assert_macros.svh =====
// Assertion macros for the read-pair feature flagger checker.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define WRPFF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wrpff assertion failed");

// Clocked assertion that also holds across reset.
`define WRPFF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wrpff reset assertion failed");

`endif

// ===== sv/wrpff_pkg.sv =====
// Shared types and constants for the read-pair feature flagger.
// No dependencies; imported by the front end, queue, back end and top level of the block.
`timescale 1ns / 1ps

package wrpff_pkg;

  localparam int SUM_BITS_DEFAULT = 48;
  localparam int QUEUE_DEPTH      = 4;
  localparam int CFG_IDX_BITS     = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INSERT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_INSERT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_READ_COV    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MATED_COV   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSERT_MEAN = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSERT_DEV  = 3'd6;

  localparam logic [2:0] CLS_NONE      = 3'd0;
  localparam logic [2:0] CLS_CORRECT   = 3'd1;
  localparam logic [2:0] CLS_ORIENT    = 3'd2;
  localparam logic [2:0] CLS_DISTANCE  = 3'd3;
  localparam logic [2:0] CLS_OTHER     = 3'd4;
  localparam logic [2:0] CLS_SINGLETON = 3'd5;

  typedef struct packed {
    logic [23:0] min_insert;
    logic [23:0] max_insert;
    logic [19:0] window_size;
    logic [31:0] read_cov;
    logic [31:0] mated_cov;
    logic [31:0] insert_mean;
    logic [31:0] insert_dev;
  } cfg_t;

  // One queued operation: a window close or an accumulate of one record.
  typedef struct packed {
    logic        is_close;
    logic        last;
    logic [23:0] ordinal;
    logic [30:0] start;
    logic [20:0] bases_l;
    logic [2:0]  cls;
    logic        dup;
    logic        ins_add;
    logic [31:0] isize;
    logic [15:0] qlen;
  } op_t;

endpackage

// ===== sv/wrpff_front.sv =====
// Front end: window tracking and record classification.
// Depends on wrpff_pkg; emits operations into the queue one per cycle while the queue has room.
`timescale 1ns / 1ps

module wrpff_front import wrpff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] ref_id,
  input  logic [24:0] mate_ref_id,
  input  logic [30:0] position,
  input  logic [31:0] mate_position,
  input  logic [31:0] template_length,
  input  logic [11:0] flags,
  input  logic [15:0] query_length,
  input  logic [30:0] contig_length,
  output op_t         push_op,
  output logic        push_valid,
  input  logic        push_ready
);

  logic        seen;
  logic [23:0] cur_contig;
  logic [23:0] counter;
  logic [31:0] wbegin;
  logic [31:0] wend;
  logic [20:0] wbases;
  logic [30:0] csize;
  logic        pend0, pend1, penda;
  op_t         op0, op1, opa;

  logic        new_contig, close_b, accept;
  logic [31:0] ws32, cl32, we1, wb1, we1p, e, sz32, wb2, we2, bases2_w;
  logic [20:0] bases1, bases2;
  logic [30:0] size1;
  logic [23:0] cnt1;
  logic        same, mm, rev, mrev, first, ok, pos_lt, pos_gt, good, ins_cond;
  logic [31:0] isize;
  logic signed [32:0] pos_s, mpos_s, start_s;
  logic signed [33:0] start34, end34, wb_s, we_s;
  logic [2:0]  cls;
  op_t         acc_op;

  function automatic op_t make_close(logic [23:0] ord, logic [31:0] st, logic [20:0] b,
                                     logic lst);
    op_t o;
    o          = '0;
    o.is_close = 1'b1;
    o.last     = lst;
    o.ordinal  = ord;
    o.start    = st[30:0];
    o.bases_l  = (b == 21'd0) ? 21'd1 : b;
    return o;
  endfunction

  always_comb begin
    ws32       = {12'd0, cfg.window_size};
    cl32       = {1'b0, contig_length};
    new_contig = !seen || (ref_id != cur_contig);
    we1        = new_contig ? ((ws32 < cl32) ? ws32 : cl32) : wend;
    we1p       = we1 + 32'd1;
    wb1        = new_contig ? 32'd0 : wbegin;
    bases1     = new_contig ? we1p[20:0] : wbases;
    size1      = new_contig ? contig_length : csize;
    cnt1       = (new_contig && seen) ? counter + 24'd1 : counter;
    close_b    = ({1'b0, position} > we1);
    e          = we1 + ws32;
    sz32       = {1'b0, size1};
    wb2        = close_b ? we1p : wb1;
    we2        = close_b ? ((e < sz32) ? e : sz32) : we1;
    bases2_w   = we2 + 32'd1 - wb2;
    bases2     = close_b ? bases2_w[20:0] : bases1;

    same  = !mate_ref_id[24] && (mate_ref_id[23:0] == ref_id);
    mm    = !flags[3];
    rev   = flags[4];
    mrev  = flags[5];
    first = flags[6];
    isize = template_length[31] ? (~template_length + 32'd1) : template_length;
    ok    = ({8'd0, cfg.min_insert} <= isize) && (isize <= {8'd0, cfg.max_insert});
    pos_s   = $signed({2'b00, position});
    mpos_s  = $signed({mate_position[31], mate_position});
    pos_lt  = pos_s < mpos_s;
    pos_gt  = pos_s > mpos_s;
    start_s = pos_lt ? pos_s : mpos_s;
    start34 = {start_s[32], start_s};
    end34   = start34 + $signed({2'b00, isize});
    wb_s    = $signed({2'b00, wb2});
    we_s    = $signed({2'b00, we2});
    ins_cond = 1'b0;
    if (first) begin
      good = pos_lt ? (!rev && mrev) : (rev && !mrev);
    end else begin
      good = pos_gt ? (rev && !mrev) : (mrev && !rev);
    end
    if (mm && same && (flags[6] || flags[7])) begin
      ins_cond = ok && (first || (start34 <= wb_s) || (end34 >= we_s));
      cls = !ok ? CLS_DISTANCE : (good ? CLS_CORRECT : CLS_ORIENT);
    end else if (!same && mm) begin
      cls = CLS_OTHER;
    end else if (!mm) begin
      cls = CLS_SINGLETON;
    end else begin
      cls = CLS_NONE;
    end
    acc_op         = '0;
    acc_op.cls     = cls;
    acc_op.dup     = flags[10];
    acc_op.ins_add = ins_cond;
    acc_op.isize   = isize;
    acc_op.qlen    = query_length;
  end

  assign in_ready   = !(pend0 || pend1 || penda);
  assign accept     = in_valid && in_ready;
  assign push_valid = pend0 || pend1 || penda;
  assign push_op    = pend0 ? op0 : (pend1 ? op1 : opa);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      cur_contig <= '0;
      counter    <= '0;
      wbegin     <= '0;
      wend       <= '0;
      wbases     <= '0;
      csize      <= '0;
      pend0      <= 1'b0;
      pend1      <= 1'b0;
      penda      <= 1'b0;
    end else if (accept) begin
      if (!flags[2]) begin
        seen        <= 1'b1;
        cur_contig  <= ref_id;
        counter     <= cnt1;
        wbegin      <= wb2;
        wend        <= we2;
        wbases      <= bases2;
        csize       <= size1;
        pend0       <= new_contig && seen;
        pend1       <= close_b;
        penda       <= 1'b1;
        op0         <= make_close(counter, wbegin, wbases, !close_b);
        op1         <= make_close(cnt1, wb1, bases1, 1'b1);
        opa         <= acc_op;
      end
    end else if (push_ready) begin
      if (pend0) begin
        pend0 <= 1'b0;
      end else if (pend1) begin
        pend1 <= 1'b0;
      end else begin
        penda <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/wrpff_queue.sv =====
// Short operation queue between the front end and the back end.
// Depends on wrpff_pkg for the operation type and depth.
`timescale 1ns / 1ps

module wrpff_queue import wrpff_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  wr_op,
  input  logic wr_valid,
  output logic wr_ready,
  output op_t  rd_op,
  output logic rd_valid,
  input  logic rd_ready
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  op_t           slots [QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign wr_ready = (count != (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = slots[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/wrpff_back.sv =====
// Back end: per-window sums and the sequenced threshold tests at window close.
// Depends on wrpff_pkg; uses one shared 32x32 multiplier over a step counter.
`timescale 1ns / 1ps

module wrpff_back import wrpff_pkg::*; #(
  parameter int SUM_BITS = SUM_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  op_t         op,
  input  logic        op_valid,
  output logic        op_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] contig_ordinal,
  output logic [30:0] closed_window_start,
  output logic [8:0]  feature_bits,
  output logic [3:0]  feature_count,
  output logic        last_of_run
);

  localparam int CW = (SUM_BITS + 18 > 56) ? SUM_BITS + 18 : 56;
  localparam int VW = SUM_BITS + 4;
  localparam int ZW = (SUM_BITS + 8 > 64) ? SUM_BITS + 8 : 64;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]  state;
  logic [3:0]  step;
  op_t         cur;

  logic [SUM_BITS-1:0] rsum, isum, csum, osum, dsum, ssum, xsum;
  logic [31:0]         icnt;

  logic [31:0]  mul_a, mul_b, sshi;
  logic [63:0]  prod, pb, t0, t1, q0, q1, q2;
  logic [52:0]  pa, pm;
  logic [ZW-1:0] dmag;
  logic         b_gt, a_gt;
  logic [95:0]  tsum;
  logic [99:0]  rhs;
  logic [127:0] sq;

  logic [ZW-1:0] a_z, b_z;
  logic [CW-1:0] r3sh, rsh, m3sh, msh, pa3, pm3;
  logic [VW-1:0] r3, s5, x5, w5;
  logic          big;
  logic [8:0]    bits;
  logic          can_emit;

  function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a, logic [31:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + (SUM_BITS+1)'(b);
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_CLOSE) begin
      case (step)
        4'd0: begin
          mul_a = cfg.read_cov;
          mul_b = {11'd0, cur.bases_l};
        end
        4'd1: begin
          mul_a = cfg.mated_cov;
          mul_b = {11'd0, cur.bases_l};
        end
        4'd2: begin
          mul_a = cfg.insert_mean;
          mul_b = icnt;
        end
        4'd3: begin
          mul_a = cfg.insert_dev;
          mul_b = cfg.insert_dev;
        end
        4'd4: begin
          mul_a = prod[31:0];
          mul_b = icnt;
        end
        4'd5: begin
          mul_a = sshi;
          mul_b = icnt;
        end
        4'd7: begin
          mul_a = dmag[31:0];
          mul_b = dmag[31:0];
        end
        4'd8: begin
          mul_a = dmag[31:0];
          mul_b = dmag[63:32];
        end
        4'd9: begin
          mul_a = dmag[63:32];
          mul_b = dmag[63:32];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    a_z  = ZW'({isum, 8'd0});
    b_z  = ZW'(pb);
    rsh  = CW'({rsum, 16'd0});
    r3sh = rsh + CW'({rsum, 17'd0});
    msh  = CW'({csum, 16'd0});
    m3sh = msh + CW'({csum, 17'd0});
    pa3  = CW'(pa) + CW'({pa, 1'b0});
    pm3  = CW'(pm) + CW'({pm, 1'b0});
    r3   = VW'(rsum) + VW'({rsum, 1'b0});
    s5   = VW'(ssum) + VW'({ssum, 2'b00});
    x5   = VW'(xsum) + VW'({xsum, 2'b00});
    w5   = VW'(dsum) + VW'({dsum, 2'b00}) + VW'(osum) + VW'({osum, 2'b00});
    big  = ((dmag >> 64) != '0) || (sq > 128'(rhs));
    bits[0] = CW'(pa) > r3sh;
    bits[1] = rsh > pa3;
    bits[2] = CW'(pm) > m3sh;
    bits[3] = msh > pm3;
    bits[4] = s5 > r3;
    bits[5] = x5 > r3;
    bits[6] = w5 > r3;
    bits[7] = (icnt == '0) || (b_gt && big);
    bits[8] = (icnt != '0) && a_gt && big;
  end

  assign op_ready = (state == ST_IDLE);
  assign can_emit = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == ST_IDLE && op_valid) begin
      cur <= op;
    end
    if (state == ST_CLOSE) begin
      case (step)
        4'd1: pa <= prod[52:0];
        4'd2: pm <= prod[52:0];
        4'd3: pb <= prod;
        4'd4: sshi <= prod[63:32];
        4'd5: t0 <= prod;
        4'd6: begin
          t1   <= prod;
          b_gt <= b_z > a_z;
          a_gt <= a_z > b_z;
          dmag <= (b_z > a_z) ? b_z - a_z : a_z - b_z;
        end
        4'd7: tsum <= 96'(t0) + {t1, 32'd0};
        4'd8: begin
          q0  <= prod;
          rhs <= 100'(tsum) + {tsum, 3'b000};
        end
        4'd9: q1 <= prod;
        4'd10: q2 <= prod;
        4'd11: sq <= 128'(q0) + 128'({q1, 33'd0}) + {q2, 64'd0};
        default: begin
        end
      endcase
    end
    if (state == ST_EMIT && can_emit) begin
      contig_ordinal      <= cur.ordinal;
      closed_window_start <= cur.start;
      feature_bits        <= bits;
      feature_count       <= 4'($countones(bits));
      last_of_run         <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      rsum      <= '0;
      isum      <= '0;
      csum      <= '0;
      osum      <= '0;
      dsum      <= '0;
      ssum      <= '0;
      xsum      <= '0;
      icnt      <= '0;
    end else begin
      if (state == ST_EMIT && can_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (op_valid) begin
            if (op.is_close) begin
              state <= ST_CLOSE;
              step  <= '0;
            end else begin
              case (op.cls)
                CLS_CORRECT:   csum <= sat_add(csum, {16'd0, op.qlen});
                CLS_ORIENT:    osum <= sat_add(osum, {16'd0, op.qlen});
                CLS_DISTANCE:  dsum <= sat_add(dsum, {16'd0, op.qlen});
                CLS_OTHER:     xsum <= sat_add(xsum, {16'd0, op.qlen});
                CLS_SINGLETON: ssum <= sat_add(ssum, {16'd0, op.qlen});
                default: begin
                end
              endcase
              if (op.ins_add) begin
                isum <= sat_add(isum, op.isize);
                icnt <= (icnt == '1) ? icnt : icnt + 32'd1;
              end
              if (!op.dup) begin
                rsum <= sat_add(rsum, {16'd0, op.qlen});
              end
            end
          end
        end
        ST_CLOSE: begin
          step <= step + 4'd1;
          if (step == 4'd11) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            state     <= ST_IDLE;
            rsum      <= '0;
            isum      <= '0;
            csum      <= '0;
            osum      <= '0;
            dsum      <= '0;
            ssum      <= '0;
            xsum      <= '0;
            icnt      <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/windowed_read_pair_feature_flagger_unit.sv =====
// Flow: a record is taken when the front end has no pending operations; it then pushes a close
// operation for each window close the record causes, then its accumulate operation, into the queue.
// Each close holds the back end from accept through the 12-step sequence over the single shared
// 32x32 multiplier to the output register load; the back end takes no new operation until then.
// The queue lets new records be taken while the back end is busy, until the queue is full.
// Reset: synchronous; configuration registers go to their defaults, sums and window state clear.
`timescale 1ns / 1ps

module windowed_read_pair_feature_flagger_unit import wrpff_pkg::*; #(
  parameter int SUM_BITS = SUM_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [23:0]             ref_id,
  input  logic [24:0]             mate_ref_id,
  input  logic [30:0]             position,
  input  logic [31:0]             mate_position,
  input  logic [31:0]             template_length,
  input  logic [11:0]             flags,
  input  logic [15:0]             query_length,
  input  logic [30:0]             contig_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             contig_ordinal,
  output logic [30:0]             closed_window_start,
  output logic [8:0]              feature_bits,
  output logic [3:0]              feature_count,
  output logic                    last_of_run
);

  cfg_t cfg;
  op_t  f_op, q_op;
  logic f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_insert  <= 24'd100;
      cfg.max_insert  <= 24'd1000000;
      cfg.window_size <= 20'd1000;
      cfg.read_cov    <= '0;
      cfg.mated_cov   <= '0;
      cfg.insert_mean <= '0;
      cfg.insert_dev  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_INSERT:  cfg.min_insert  <= cfg_data[23:0];
        REG_MAX_INSERT:  cfg.max_insert  <= cfg_data[23:0];
        REG_WINDOW_SIZE: cfg.window_size <= cfg_data[19:0];
        REG_READ_COV:    cfg.read_cov    <= cfg_data;
        REG_MATED_COV:   cfg.mated_cov   <= cfg_data;
        REG_INSERT_MEAN: cfg.insert_mean <= cfg_data;
        REG_INSERT_DEV:  cfg.insert_dev  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wrpff_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .ref_id          (ref_id),
    .mate_ref_id     (mate_ref_id),
    .position        (position),
    .mate_position   (mate_position),
    .template_length (template_length),
    .flags           (flags),
    .query_length    (query_length),
    .contig_length   (contig_length),
    .push_op         (f_op),
    .push_valid      (f_valid),
    .push_ready      (f_ready)
  );

  wrpff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_op    (f_op),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_op    (q_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  wrpff_back #(.SUM_BITS(SUM_BITS)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .op                  (q_op),
    .op_valid            (q_valid),
    .op_ready            (q_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .contig_ordinal      (contig_ordinal),
    .closed_window_start (closed_window_start),
    .feature_bits        (feature_bits),
    .feature_count       (feature_count),
    .last_of_run         (last_of_run)
  );

endmodule

// ===== sv/wrpff_checker.sv =====
// Port-level checker for the read-pair feature flagger, with its bind.
// Depends on assert_macros.svh; attaches to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrpff_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] feature_bits,
  input logic [3:0] feature_count
);

  `WRPFF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(feature_bits))
  `WRPFF_ASSERT(a_count, clk, rst, out_valid |-> feature_count == 4'($countones(feature_bits)))
  `WRPFF_ASSERT(a_z_excl, clk, rst, out_valid |-> !(feature_bits[7] && feature_bits[8]))
  `WRPFF_ASSERT(a_cov_excl, clk, rst, out_valid |-> !(feature_bits[0] && feature_bits[1]))
  `WRPFF_ASSERT_RST(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind windowed_read_pair_feature_flagger_unit wrpff_checker u_wrpff_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .feature_bits  (feature_bits),
  .feature_count (feature_count)
);

// ===== tb/tb.sv =====
// Self-checking testbench for windowed_read_pair_feature_flagger_unit.
// Drives alignment records and compares each closed-window word against a local predictor.
// Depends on wrpff_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
  import wrpff_pkg::*;

  localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;
  localparam int RAND_ITEMS = 1930;
  localparam int QUIET_ITEMS = 200;
  localparam int PHASES = 8;

  typedef struct {
    logic [23:0] ref_id;
    logic [24:0] mate_ref_id;
    logic [30:0] position;
    logic [31:0] mate_position;
    logic [31:0] template_length;
    logic [11:0] flags;
    logic [15:0] query_length;
    logic [30:0] contig_length;
  } rec_t;

  typedef struct {
    logic [23:0] ordinal;
    logic [30:0] start;
    logic [8:0]  bits;
    logic [3:0]  count;
    logic        last;
  } win_t;

  typedef struct {
    rec_t r;
    bit   typed;
    win_t w;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_MIN_INSERT;
  logic [31:0] cfg_data = 32'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [23:0] ref_id = '0;
  logic [24:0] mate_ref_id = '0;
  logic [30:0] position = '0;
  logic [31:0] mate_position = '0;
  logic [31:0] template_length = '0;
  logic [11:0] flags = '0;
  logic [15:0] query_length = '0;
  logic [30:0] contig_length = 31'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] contig_ordinal;
  logic [30:0] closed_window_start;
  logic [8:0] feature_bits;
  logic [3:0] feature_count;
  logic last_of_run;

  windowed_read_pair_feature_flagger_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor configuration and state.
  logic [63:0] c_min, c_max, c_ws, c_rcov, c_mcov, c_mean, c_dev;
  bit          p_seen;
  logic [63:0] p_ref, p_ord, w_begin, w_end, w_bases, p_csize;
  logic [63:0] s_read, s_icnt, s_ilen, s_good, s_orient, s_dist, s_single, s_other;

  win_t expected_windows[$];
  int   errors = 0;
  bit   quiet = 1'b0;

  // Stimulus generator position.
  logic [23:0] g_ref;
  longint      g_pos;
  logic [30:0] g_cl;

  function automatic logic [63:0] sat(logic [63:0] a, logic [63:0] q, logic [63:0] mx);
    return (a > mx - q) ? mx : a + q;
  endfunction

  function automatic bit big_dev(logic [127:0] d, logic [127:0] rhs);
    return d[127:64] != 0 || (128'(d[63:0]) * d[63:0]) > rhs;
  endfunction

  function automatic win_t close_window();
    logic [63:0]  len, sq;
    logic [127:0] r3, r5w, a, b, t, rhs;
    logic [8:0]   bits;
    win_t         o;
    len = (w_bases != 0) ? w_bases : 64'd1;
    bits = '0;
    r3 = 128'(s_read) * 3;
    r5w = 128'(s_dist) * 5 + 128'(s_orient) * 5;
    if (128'(c_rcov) * len > 128'(s_read) * 196608) bits[0] = 1'b1;
    if (128'(s_read) * 65536 > 128'(c_rcov) * (3 * len)) bits[1] = 1'b1;
    if (128'(c_mcov) * len > 128'(s_good) * 196608) bits[2] = 1'b1;
    if (128'(s_good) * 65536 > 128'(c_mcov) * (3 * len)) bits[3] = 1'b1;
    if (128'(s_single) * 5 > r3) bits[4] = 1'b1;
    if (128'(s_other) * 5 > r3) bits[5] = 1'b1;
    if (r5w > r3) bits[6] = 1'b1;
    if (s_icnt == 0) begin
      bits[7] = 1'b1;
    end else begin
      a = 128'(s_ilen) << 8;
      b = 128'(c_mean) * s_icnt;
      sq = c_dev * c_dev;
      t = 128'(sq) * s_icnt;
      rhs = t * 9;
      if (b > a && big_dev(b - a, rhs)) bits[7] = 1'b1;
      if (a > b && big_dev(a - b, rhs)) bits[8] = 1'b1;
    end
    o.ordinal = p_ord[23:0];
    o.start = w_begin[30:0];
    o.bits = bits;
    o.count = 4'($countones(bits));
    o.last = 1'b0;
    {s_read, s_icnt, s_ilen, s_good, s_orient, s_dist, s_single, s_other} = '0;
    return o;
  endfunction

  function automatic int predict_windows(rec_t r);
    win_t        outs[2];
    int          n;
    longint      mtid, pos, mpos, st, en;
    logic [63:0] isize, e;
    bit          same, mmap, rev, mrev, ok, first, good;
    n = 0;
    if (r.flags[2]) return 0;
    mtid = r.mate_ref_id[24] ? longint'(r.mate_ref_id) - 64'h200_0000 : longint'(r.mate_ref_id);
    pos = longint'(r.position);
    mpos = r.mate_position[31] ? longint'(r.mate_position) - 64'h1_0000_0000
                               : longint'(r.mate_position);
    isize = r.template_length[31] ? 64'h1_0000_0000 - r.template_length : 64'(r.template_length);
    if (!p_seen || 64'(r.ref_id) != p_ref) begin
      if (p_seen) begin
        outs[n] = close_window();
        n++;
        p_ord = (p_ord + 1) & 64'hFF_FFFF;
      end
      p_seen = 1'b1;
      p_ref = 64'(r.ref_id);
      p_csize = 64'(r.contig_length);
      w_begin = 0;
      w_end = (c_ws < p_csize) ? c_ws : p_csize;
      w_bases = w_end + 1;
    end
    if (64'(pos) > w_end) begin
      outs[n] = close_window();
      n++;
      w_begin = w_end + 1;
      e = w_end + c_ws;
      w_end = (e < p_csize) ? e : p_csize;
      w_bases = w_end + 1 - w_begin;
    end
    same = mtid >= 0 && mtid == longint'(r.ref_id);
    mmap = !r.flags[3];
    rev = r.flags[4];
    mrev = r.flags[5];
    ok = c_min <= isize && isize <= c_max;
    if (mmap && same && (r.flags[6] || r.flags[7])) begin
      first = r.flags[6];
      st = (pos < mpos) ? pos : mpos;
      en = st + longint'(isize);
      if (ok && (first || st <= longint'(w_begin) || en >= longint'(w_end))) begin
        s_ilen = sat(s_ilen, isize, SUM_MAX);
        s_icnt = sat(s_icnt, 1, CNT_MAX);
      end
      if (first) good = (pos < mpos) ? (!rev && mrev) : (rev && !mrev);
      else good = (pos > mpos) ? (rev && !mrev) : (mrev && !rev);
      if (!ok) s_dist = sat(s_dist, r.query_length, SUM_MAX);
      else if (good) s_good = sat(s_good, r.query_length, SUM_MAX);
      else s_orient = sat(s_orient, r.query_length, SUM_MAX);
    end else if (!same && mmap) begin
      s_other = sat(s_other, r.query_length, SUM_MAX);
    end else if (!mmap) begin
      s_single = sat(s_single, r.query_length, SUM_MAX);
    end
    if (!r.flags[10]) s_read = sat(s_read, r.query_length, SUM_MAX);
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_windows.push_back(outs[i]);
    return n;
  endfunction

  function automatic int idle_burst();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  task automatic send_record(rec_t r, bit typed, win_t w);
    int g, n;
    g = idle_burst();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    ref_id <= r.ref_id;
    mate_ref_id <= r.mate_ref_id;
    position <= r.position;
    mate_position <= r.mate_position;
    template_length <= r.template_length;
    flags <= r.flags;
    query_length <= r.query_length;
    contig_length <= r.contig_length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = predict_windows(r);
    if (typed) expected_windows[expected_windows.size()-1] = w;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_MIN_INSERT:  c_min = 64'(v[23:0]);
      REG_MAX_INSERT:  c_max = 64'(v[23:0]);
      REG_WINDOW_SIZE: c_ws = 64'(v[19:0]);
      REG_READ_COV:    c_rcov = 64'(v);
      REG_MATED_COV:   c_mcov = 64'(v);
      REG_INSERT_MEAN: c_mean = 64'(v);
      REG_INSERT_DEV:  c_dev = 64'(v);
      default: ;
    endcase
  endtask

  task automatic configure(int ph);
    logic [31:0] v[7];
    case (ph)
      0: v = '{100, 2000, 500, 32'h0002_0000, 32'h0001_0000, 300 * 256, 40 * 256};
      1: v = '{0, 24'hFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      2: v = '{24'hFF_FFFF, 0, 20'hF_FFFF, 0, 0, 0, 0};
      3: v = '{50, 1500, 200, 32'h0001_8000, 32'h0000_C000, 400 * 256, 0};
      default: begin
        v[0] = $urandom_range(0, 400);
        v[1] = $urandom_range(300, 3000);
        v[2] = $urandom_range(20, 2000);
        v[3] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
        v[4] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
        v[5] = $urandom_range(100 * 256, 800 * 256);
        v[6] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 200 * 256);
      end
    endcase
    cfg_put(REG_MIN_INSERT, v[0]);
    cfg_put(REG_MAX_INSERT, v[1]);
    cfg_put(REG_WINDOW_SIZE, v[2]);
    cfg_put(REG_READ_COV, v[3]);
    cfg_put(REG_MATED_COV, v[4]);
    cfg_put(REG_INSERT_MEAN, v[5]);
    cfg_put(REG_INSERT_DEV, v[6]);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rec_t mk(logic [23:0] rf, logic [24:0] mr, logic [30:0] p,
                              logic [31:0] mp, logic [31:0] tl, logic [11:0] fl,
                              logic [15:0] q, logic [30:0] cl);
    rec_t r;
    r = '{rf, mr, p, mp, tl, fl, q, cl};
    return r;
  endfunction

  function automatic rec_t random_record();
    rec_t        r;
    longint      ws, mp, d;
    logic [11:0] fl;
    ws = (c_ws > 0) ? longint'(c_ws) : 1;
    if ($urandom_range(0, 99) < 10) begin
      r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (r.contig_length == 0) r.contig_length = 31'd1;
      return r;
    end
    if ($urandom_range(0, 99) < 3) begin
      g_ref = ($urandom_range(0, 1) == 0) ? g_ref + 24'd1 : 24'($urandom);
      g_pos = 0;
      case ($urandom_range(0, 9))
        0: g_cl = 31'($urandom_range(1, 300));
        1: g_cl = 31'($urandom);
        default: g_cl = 31'($urandom_range(32'(ws), 32'(ws) * 20 > 32'h7FFF_FFFF ?
                                           32'h7FFF_FFFF : 32'(ws) * 20));
      endcase
      if (g_cl == 0) g_cl = 31'd1;
    end
    if ($urandom_range(0, 99) < 2) g_pos = longint'($urandom_range(0, 32'h7FFF_FFFF));
    else g_pos = g_pos + $urandom_range(0, 32'(ws / 4 + 1));
    if (g_pos > 64'h7FFF_FFFF) g_pos = 64'h7FFF_FFFF;
    d = longint'($urandom_range(0, 1500));
    mp = ($urandom_range(0, 1) == 0) ? g_pos + d : g_pos - d;
    if (mp < 0) mp = 0;
    fl = 12'($urandom) & 12'hB03;
    fl[2] = ($urandom_range(0, 19) == 0);
    fl[3] = ($urandom_range(0, 9) == 0);
    fl[5:4] = 2'($urandom);
    fl[7:6] = 2'($urandom);
    fl[10] = ($urandom_range(0, 19) == 0);
    r.ref_id = g_ref;
    r.mate_ref_id = ($urandom_range(0, 9) == 0) ? 25'($urandom) : {1'b0, g_ref};
    r.position = 31'(g_pos);
    r.mate_position = 32'(mp);
    r.template_length = (mp >= g_pos) ? 32'(mp - g_pos + 100) : -32'(g_pos - mp + 100);
    r.flags = fl;
    r.query_length = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(30, 250));
    r.contig_length = g_cl;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    int   stall;
    win_t e;
    if (rst) begin
      out_ready <= 1'b1;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: unexpected word ord=%0d start=%0d bits=%h", $realtime,
                   contig_ordinal, closed_window_start, feature_bits);
          errors++;
        end else begin
          e = expected_windows.pop_front();
          if (contig_ordinal !== e.ordinal) begin
            $display("%0t: contig_ordinal expected %0d actual %0d", $realtime, e.ordinal,
                     contig_ordinal);
            errors++;
          end
          if (closed_window_start !== e.start) begin
            $display("%0t: closed_window_start expected %0d actual %0d", $realtime, e.start,
                     closed_window_start);
            errors++;
          end
          if (feature_bits !== e.bits) begin
            $display("%0t: feature_bits expected %h actual %h", $realtime, e.bits,
                     feature_bits);
            errors++;
          end
          if (feature_count !== e.count) begin
            $display("%0t: feature_count expected %0d actual %0d", $realtime, e.count,
                     feature_count);
            errors++;
          end
          if (last_of_run !== e.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $realtime, e.last,
                     last_of_run);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    row_t rows[$];
    win_t none, w;
    row_t row;
    int   per_phase;
    none = '{0, 0, 0, 0, 0};
    c_min = 100; c_max = 1000000; c_ws = 1000;
    c_rcov = 0; c_mcov = 0; c_mean = 0; c_dev = 0;
    p_seen = 0; p_ref = 0; p_ord = 0; w_begin = 0; w_end = 0; w_bases = 0; p_csize = 0;
    {s_read, s_icnt, s_ilen, s_good, s_orient, s_dist, s_single, s_other} = '0;
    g_ref = 24'd100; g_pos = 0; g_cl = 31'd20000;

    rows.push_back('{mk(5, 0, 10, 0, 0, 12'h008, 100, 5000), 0, none});
    // New contig closes the first window: high coverage, singleton, empty insert set.
    w = '{24'd0, 31'd0, 9'h092, 4'd3, 1'b1};
    rows.push_back('{mk(6, 0, 20, 0, 0, 12'h008, 50, 3000), 1, w});
    rows.push_back('{mk(7, 7, 30, 40, 10, 12'h004, 80, 9000), 0, none});
    rows.push_back('{mk(6, 6, 100, 400, 350, 12'h060, 150, 1), 0, none});
    rows.push_back('{mk(6, 6, 400, 100, -32'sd350, 12'h090, 150, 1), 0, none});
    rows.push_back('{mk(6, 6, 410, 700, 290, 12'h040, 120, 1), 0, none});
    rows.push_back('{mk(6, 6, 420, 440, 50, 12'h061, 120, 1), 0, none});
    rows.push_back('{mk(6, 9, 430, 50, 0, 12'h001, 90, 1), 0, none});
    rows.push_back('{mk(6, 25'h1FF_FFFF, 440, 32'hFFFF_FFFF, 0, 12'h001, 90, 1), 0, none});
    rows.push_back('{mk(6, 0, 450, 0, 0, 12'h408, 70, 1), 0, none});
    rows.push_back('{mk(6, 6, 460, 600, 200, 12'h001, 60, 1), 0, none});
    rows.push_back('{mk(6, 6, 470, 32'hFFFF_FFFF, 32'h8000_0000, 12'h040, 60, 1), 0, none});
    rows.push_back('{mk(6, 6, 1500, 1200, -32'sd400, 12'h090, 100, 1), 0, none});
    rows.push_back('{mk(6, 6, 5000, 5300, 400, 12'h060, 100, 1), 0, none});
    rows.push_back('{mk(6, 0, 6000, 0, 0, 12'h008, 100, 1), 0, none});
    rows.push_back('{mk(6, 0, 7000, 0, 0, 12'h008, 100, 1), 0, none});
    rows.push_back('{mk(24'hFF_FFFF, 25'h0FF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 12'hFFB, 16'hFFFF, 31'h7FFF_FFFF), 0, none});
    rows.push_back('{mk(24'hFF_FFFF, 25'h0FF_FFFF, 0, 0, 0, 12'hBF3, 16'hFFFF, 1), 0, none});
    rows.push_back('{mk(0, 0, 0, 0, 0, 12'h000, 0, 1), 0, none});
    rows.push_back('{mk(0, 0, 5, 0, 0, 12'h000, 0, 1), 0, none});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      row = rows[i];
      send_record(row.r, row.typed, row.w);
    end
    drain();

    per_phase = RAND_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(ph);
      for (int k = 0; k < per_phase; k++) begin
        if (ph == PHASES - 1 && k >= per_phase - QUIET_ITEMS) quiet = 1'b1;
        send_record(random_record(), 0, none);
        if (ph == 3 && k == per_phase / 2) drain();
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wrpff_pkg.sv
sv/wrpff_front.sv
sv/wrpff_queue.sv
sv/wrpff_back.sv
sv/windowed_read_pair_feature_flagger_unit.sv
sv/wrpff_checker.sv
tb/tb.sv
